/* hw/rtl/tccw_pkg.sv */
// Shared types and constants for the text console cell writer.
// Used by the top level, front end and back end; no dependencies of its own.
package tccw_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 64;
  localparam int COL_AW      = $clog2(MAX_COLUMNS);
  localparam int ROW_AW      = $clog2(MAX_ROWS);
  localparam int ADDR_W      = COL_AW + ROW_AW;
  localparam int CELL_DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int CELL_W      = 32;

  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_NEWLINE   = 8'h0a;
  localparam logic [7:0] CH_RETURN    = 8'h0d;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;

  localparam logic [7:0]        RESET_FG   = 8'd7;
  localparam logic [CELL_W-1:0] RESET_CELL = {8'h00, 8'h00, RESET_FG, CH_SPACE};

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_SET   = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  localparam logic [2:0] REG_COLUMNS = 3'd0;
  localparam logic [2:0] REG_ROWS    = 3'd1;
  localparam logic [2:0] REG_FG      = 3'd2;
  localparam logic [2:0] REG_BG      = 3'd3;
  localparam logic [2:0] REG_ATTR    = 3'd4;

  typedef enum logic [2:0] {
    K_NEWLINE,
    K_RETURN,
    K_BACKSPACE,
    K_PRINT,
    K_SET,
    K_CLEAR,
    K_READ
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic [7:0] px;
    logic [6:0] py;
  } cmd_t;

  // effective geometry: cols 1..MAX_COLUMNS, rows 1..MAX_ROWS
  typedef struct packed {
    logic [7:0] cols;
    logic [6:0] rows;
    logic [7:0] fg;
    logic [7:0] bg;
    logic [7:0] attr;
  } cfg_t;

endpackage

/* hw/rtl/text_console_cell_writer_core.sv */
// Text console cell writer, top level: configuration registers plus the
// front end, command queue and back end. Uses tccw_pkg, tccw_front, tccw_back.
//
// Keeps a 128 x 64 screen of 32-bit cells (char, fg, bg, attr) and a cursor.
// After reset the block sweeps the whole cell RAM to blank cells, one cell a
// cycle; s_tready stays low until that pass is done, while configuration
// writes are taken as usual. Afterwards control bytes and printable bytes
// that need no scroll, set cursor and out-of-range reads are handled in the
// idle state itself, and an in-range read cell goes on through a read state
// (registered RAM read). A scroll copies the rows in use up one row through
// the single write port in the scroll state (skipped with a single row; the
// last copy lands in the blank state), then blanks the bottom row, and a put
// state places a pending character. A clear screen blanks the rows*cols
// cells in use and homes the cursor. A two-word queue lets input words be
// taken while the back end scrolls or a result waits on m_tready.
module text_console_cell_writer_core import tccw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_code[7:0], pos_x[15:8], pos_y[22:16]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // cursor_col[7:0], cursor_row[13:8], scrolled[14], bad_position[15],
  // cell_char[23:16], cell_fg[31:24], cell_bg[39:32], cell_attr[47:40]
  output logic [47:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] column_count;
  logic [6:0] row_count;
  logic [7:0] foreground_colour;
  logic [7:0] background_colour;
  logic [7:0] attribute_bits;
  cfg_t       cfg;
  logic       init_done;
  logic       q_valid;
  cmd_t       q_cmd;
  logic       q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count      <= 8'd80;
      row_count         <= 7'd24;
      foreground_colour <= RESET_FG;
      background_colour <= 8'd0;
      attribute_bits    <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMNS: column_count      <= cfg_data;
        REG_ROWS:    row_count         <= cfg_data[6:0];
        REG_FG:      foreground_colour <= cfg_data;
        REG_BG:      background_colour <= cfg_data;
        REG_ATTR:    attribute_bits    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (column_count == 8'd0) begin
      cfg.cols = 8'd1;
    end else if (column_count > 8'(MAX_COLUMNS)) begin
      cfg.cols = 8'(MAX_COLUMNS);
    end else begin
      cfg.cols = column_count;
    end
    priority if (row_count == 7'd0) begin
      cfg.rows = 7'd1;
    end else if (row_count > 7'(MAX_ROWS)) begin
      cfg.rows = 7'(MAX_ROWS);
    end else begin
      cfg.rows = row_count;
    end
    cfg.fg   = foreground_colour;
    cfg.bg   = background_colour;
    cfg.attr = attribute_bits;
  end

  tccw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .init_done(init_done),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  tccw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .init_done(init_done),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

/* hw/rtl/tccw_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tccw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/tccw_front.sv */
// Front end: accepts input words, classifies them into commands and
// holds them in a two-entry queue for the back end. Uses tccw_pkg.
module tccw_front import tccw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_code[7:0], pos_x[15:8], pos_y[22:16]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  input  logic        init_done,
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  logic        q_pop
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cmd_in;
  logic       push;

  always_comb begin
    cmd_in.ch = s_tdata[7:0];
    cmd_in.px = s_tdata[15:8];
    cmd_in.py = s_tdata[22:16];
    unique case (s_tuser)
      MODE_PUT: begin
        priority if (s_tdata[7:0] == CH_NEWLINE) begin
          cmd_in.kind = K_NEWLINE;
        end else if (s_tdata[7:0] == CH_RETURN) begin
          cmd_in.kind = K_RETURN;
        end else if (s_tdata[7:0] == CH_BACKSPACE) begin
          cmd_in.kind = K_BACKSPACE;
        end else begin
          cmd_in.kind = K_PRINT;
        end
      end
      MODE_SET:   cmd_in.kind = K_SET;
      MODE_CLEAR: cmd_in.kind = K_CLEAR;
      MODE_READ:  cmd_in.kind = K_READ;
      default:    cmd_in.kind = K_READ;
    endcase
  end

  assign s_tready = init_done && (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/tccw_back.sv */
// Back end: owns the cursor and the cell RAM, executes queued commands
// (print, scroll, clear, read) and holds the result word.
// Uses tccw_pkg and tccw_ram.
module tccw_back import tccw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        init_done,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata
);

  typedef enum logic [6:0] {
    ST_INIT   = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_SCROLL = 7'b0000100,
    ST_BLANK  = 7'b0001000,
    ST_PUT    = 7'b0010000,
    ST_CLEAR  = 7'b0100000,
    ST_READ   = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [7:0]        cur_col, col_next;
  logic [ROW_AW-1:0] cur_row, row_next;
  logic [ROW_AW-1:0] rr, rr_next;
  logic [COL_AW-1:0] cc, cc_next;
  logic [7:0]        put_ch, put_ch_next;
  logic              print_pend, print_pend_next;
  logic              cp_pend, cp_pend_next;
  logic [ADDR_W-1:0] cp_addr, cp_addr_next;

  logic              out_valid;
  logic [7:0]        out_col;
  logic [ROW_AW-1:0] out_row;
  logic              out_scr;
  logic              out_bad;
  logic [CELL_W-1:0] out_cell;

  logic              emit, emit_scr, emit_bad;
  logic [CELL_W-1:0] emit_cell;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CELL_W-1:0] wdata, rdata;

  logic [COL_AW-1:0] cols_m1;
  logic [ROW_AW-1:0] rows_m1;
  logic [ROW_AW-1:0] row0;
  logic              wrap;
  logic [CELL_W-1:0] blank;
  logic [CELL_W-1:0] print_cell;

  tccw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELL_DEPTH)
  ) u_cells (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign cols_m1    = COL_AW'(cfg.cols - 8'd1);
  assign rows_m1    = ROW_AW'(cfg.rows - 7'd1);
  assign row0       = ({1'b0, cur_row} >= cfg.rows) ? rows_m1 : cur_row;
  assign wrap       = (cur_col >= cfg.cols);
  assign blank      = {8'h00, cfg.bg, cfg.fg, CH_SPACE};
  assign print_cell = {cfg.attr, cfg.bg, cfg.fg, q_cmd.ch};
  assign init_done  = (state != ST_INIT);

  always_comb begin
    state_next      = state;
    col_next        = cur_col;
    row_next        = cur_row;
    rr_next         = rr;
    cc_next         = cc;
    put_ch_next     = put_ch;
    print_pend_next = print_pend;
    cp_pend_next    = 1'b0;
    cp_addr_next    = cp_addr;
    emit            = 1'b0;
    emit_scr        = 1'b0;
    emit_bad        = 1'b0;
    emit_cell       = '0;
    q_pop           = 1'b0;
    we              = 1'b0;
    waddr           = '0;
    wdata           = '0;
    raddr           = '0;

    unique case (state)
      ST_INIT: begin
        we      = 1'b1;
        waddr   = {rr, cc};
        wdata   = RESET_CELL;
        cc_next = cc + 1'b1;
        if (cc == {COL_AW{1'b1}}) begin
          rr_next = rr + 1'b1;
          if (rr == {ROW_AW{1'b1}}) begin
            state_next = ST_IDLE;
          end
        end
      end

      ST_IDLE: begin
        if (q_valid && (!out_valid || m_tready)) begin
          q_pop = 1'b1;
          unique case (q_cmd.kind)
            K_NEWLINE: begin
              col_next = 8'd0;
              if (row0 == rows_m1) begin
                row_next        = rows_m1;
                print_pend_next = 1'b0;
                cc_next         = '0;
                rr_next         = ROW_AW'(1);
                state_next      = (rows_m1 == '0) ? ST_BLANK : ST_SCROLL;
              end else begin
                row_next = row0 + 1'b1;
                emit     = 1'b1;
              end
            end
            K_RETURN: begin
              col_next = 8'd0;
              row_next = row0;
              emit     = 1'b1;
            end
            K_BACKSPACE: begin
              row_next = row0;
              if (cur_col != 8'd0) begin
                col_next = cur_col - 8'd1;
              end
              emit = 1'b1;
            end
            K_PRINT: begin
              if (wrap) begin
                col_next = 8'd1;
                if (row0 == rows_m1) begin
                  row_next        = rows_m1;
                  print_pend_next = 1'b1;
                  put_ch_next     = q_cmd.ch;
                  cc_next         = '0;
                  rr_next         = ROW_AW'(1);
                  state_next      = (rows_m1 == '0) ? ST_BLANK : ST_SCROLL;
                end else begin
                  row_next = row0 + 1'b1;
                  we       = 1'b1;
                  waddr    = {row0 + 1'b1, {COL_AW{1'b0}}};
                  wdata    = print_cell;
                  emit     = 1'b1;
                end
              end else begin
                we       = 1'b1;
                waddr    = {row0, cur_col[COL_AW-1:0]};
                wdata    = print_cell;
                col_next = cur_col + 8'd1;
                row_next = row0;
                emit     = 1'b1;
              end
            end
            K_SET: begin
              if (q_cmd.px < cfg.cols) begin
                col_next = q_cmd.px;
              end else begin
                emit_bad = 1'b1;
              end
              if (q_cmd.py < cfg.rows) begin
                row_next = q_cmd.py[ROW_AW-1:0];
              end else begin
                emit_bad = 1'b1;
              end
              emit = 1'b1;
            end
            K_CLEAR: begin
              rr_next    = '0;
              cc_next    = '0;
              state_next = ST_CLEAR;
            end
            K_READ: begin
              if ((q_cmd.px < cfg.cols) && (q_cmd.py < cfg.rows)) begin
                raddr      = {q_cmd.py[ROW_AW-1:0], q_cmd.px[COL_AW-1:0]};
                state_next = ST_READ;
              end else begin
                emit     = 1'b1;
                emit_bad = 1'b1;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      ST_SCROLL: begin
        // read source row rr; the registered read data is written one row up at cp_addr
        raddr        = {rr, cc};
        cp_pend_next = 1'b1;
        cp_addr_next = {rr - 1'b1, cc};
        if (cp_pend) begin
          we    = 1'b1;
          waddr = cp_addr;
          wdata = rdata;
        end
        if (cc == cols_m1) begin
          cc_next = '0;
          if (rr == rows_m1) begin
            state_next = ST_BLANK;
          end else begin
            rr_next = rr + 1'b1;
          end
        end else begin
          cc_next = cc + 1'b1;
        end
      end

      ST_BLANK: begin
        if (cp_pend) begin
          we    = 1'b1;
          waddr = cp_addr;
          wdata = rdata;
        end else begin
          we    = 1'b1;
          waddr = {rows_m1, cc};
          wdata = blank;
          if (cc == cols_m1) begin
            if (print_pend) begin
              state_next = ST_PUT;
            end else begin
              emit       = 1'b1;
              emit_scr   = 1'b1;
              state_next = ST_IDLE;
            end
          end else begin
            cc_next = cc + 1'b1;
          end
        end
      end

      ST_PUT: begin
        we              = 1'b1;
        waddr           = {cur_row, {COL_AW{1'b0}}};
        wdata           = {cfg.attr, cfg.bg, cfg.fg, put_ch};
        print_pend_next = 1'b0;
        emit            = 1'b1;
        emit_scr        = 1'b1;
        state_next      = ST_IDLE;
      end

      ST_CLEAR: begin
        we    = 1'b1;
        waddr = {rr, cc};
        wdata = blank;
        if (cc == cols_m1) begin
          cc_next = '0;
          if (rr == rows_m1) begin
            col_next   = 8'd0;
            row_next   = '0;
            emit       = 1'b1;
            state_next = ST_IDLE;
          end else begin
            rr_next = rr + 1'b1;
          end
        end else begin
          cc_next = cc + 1'b1;
        end
      end

      ST_READ: begin
        emit       = 1'b1;
        emit_cell  = rdata;
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      cur_col    <= 8'd0;
      cur_row    <= '0;
      rr         <= '0;
      cc         <= '0;
      print_pend <= 1'b0;
      cp_pend    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cur_col    <= col_next;
      cur_row    <= row_next;
      rr         <= rr_next;
      cc         <= cc_next;
      print_pend <= print_pend_next;
      cp_pend    <= cp_pend_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    put_ch  <= put_ch_next;
    cp_addr <= cp_addr_next;
    if (emit) begin
      out_col  <= col_next;
      out_row  <= row_next;
      out_scr  <= emit_scr;
      out_bad  <= emit_bad;
      out_cell <= emit_cell;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_cell, out_bad, out_scr, out_row, out_col};

endmodule

/* tb/tb_text_console_cell_writer_core.sv */
// Self-checking testbench for text_console_cell_writer_core: a cursor and screen
// model predicts every result word. Depends on tccw_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_text_console_cell_writer_core;
  import tccw_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int ITEMS_PER_PHASE = 115;

  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] bg;
    logic [7:0] fg;
    logic [7:0] ch;
    logic       bad;
    logic       scrolled;
    logic [5:0] row;
    logic [7:0] col;
  } console_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // char_code[7:0], pos_x[15:8], pos_y[22:16]
  logic [1:0]  s_tuser;   // mode[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // cursor_col[7:0], cursor_row[13:8], scrolled[14], bad_position[15],
  // cell_char[23:16], cell_fg[31:24], cell_bg[39:32], cell_attr[47:40]
  logic [47:0] m_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;

  // screen and cursor model
  logic [31:0] screen_model [CELL_DEPTH];
  int          cur_x;
  int          cur_y;
  logic [7:0]  reg_cols = 8'd80;
  logic [6:0]  reg_rows = 7'd24;
  logic [7:0]  reg_fg   = RESET_FG;
  logic [7:0]  reg_bg   = 8'd0;
  logic [7:0]  reg_attr = 8'd0;

  console_result_t due_results [$];
  console_result_t got_result;
  console_result_t want_result;
  int              mismatches = 0;
  int              cycles = 0;
  bit              idle_on = 1'b1;
  int              burst_left = 0;
  int              stall_left = 0;

  text_console_cell_writer_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, due_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int cols_used();
    if (reg_cols == 8'd0) return 1;
    if (reg_cols > MAX_COLUMNS) return MAX_COLUMNS;
    return int'(reg_cols);
  endfunction

  function automatic int rows_used();
    if (reg_rows == 7'd0) return 1;
    if (reg_rows > MAX_ROWS) return MAX_ROWS;
    return int'(reg_rows);
  endfunction

  // cursor to column 0 of the next row, scrolling the area in use if needed
  function automatic logic line_feed(int cols, int rows);
    cur_x = 0;
    cur_y++;
    if (cur_y >= rows) begin
      for (int r = 1; r < rows; r++)
        for (int c = 0; c < cols; c++)
          screen_model[(r - 1) * MAX_COLUMNS + c] = screen_model[r * MAX_COLUMNS + c];
      for (int c = 0; c < cols; c++)
        screen_model[(rows - 1) * MAX_COLUMNS + c] = {8'h00, reg_bg, reg_fg, CH_SPACE};
      cur_y = rows - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic console_result_t predict_console_step(logic [1:0] mode, logic [7:0] ch,
                                                          logic [7:0] px, logic [6:0] py);
    console_result_t res;
    logic [31:0]     rd_cell;
    int              cols;
    int              rows;
    cols    = cols_used();
    rows    = rows_used();
    res     = '0;
    rd_cell = '0;
    case (mode)
      MODE_PUT: begin
        if (cur_y >= rows) cur_y = rows - 1;
        if (ch == CH_NEWLINE) begin
          res.scrolled = line_feed(cols, rows);
        end else if (ch == CH_RETURN) begin
          cur_x = 0;
        end else if (ch == CH_BACKSPACE) begin
          if (cur_x > 0) cur_x--;
        end else begin
          if (cur_x >= cols) res.scrolled = line_feed(cols, rows);
          screen_model[cur_y * MAX_COLUMNS + cur_x] = {reg_attr, reg_bg, reg_fg, ch};
          cur_x++;
        end
      end
      MODE_SET: begin
        if (int'(px) < cols) cur_x = int'(px); else res.bad = 1'b1;
        if (int'(py) < rows) cur_y = int'(py); else res.bad = 1'b1;
      end
      MODE_CLEAR: begin
        for (int r = 0; r < rows; r++)
          for (int c = 0; c < cols; c++)
            screen_model[r * MAX_COLUMNS + c] = {8'h00, reg_bg, reg_fg, CH_SPACE};
        cur_x = 0;
        cur_y = 0;
      end
      default: begin
        if (int'(px) < cols && int'(py) < rows)
          rd_cell = screen_model[int'(py) * MAX_COLUMNS + int'(px)];
        else res.bad = 1'b1;
      end
    endcase
    res.col  = cur_x[7:0];
    res.row  = cur_y[5:0];
    res.ch   = rd_cell[7:0];
    res.fg   = rd_cell[15:8];
    res.bg   = rd_cell[23:16];
    res.attr = rd_cell[31:24];
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_result = m_tdata;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", m_tdata);
      end else begin
        want_result = due_results.pop_front();
        if (got_result.col !== want_result.col || got_result.row !== want_result.row ||
            got_result.scrolled !== want_result.scrolled || got_result.bad !== want_result.bad ||
            got_result.ch !== want_result.ch || got_result.fg !== want_result.fg ||
            got_result.bg !== want_result.bg || got_result.attr !== want_result.attr) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp col=%0d row=%0d scr=%b bad=%b cell=%h",
                      " | got col=%0d row=%0d scr=%b bad=%b cell=%h"},
                     want_result.col, want_result.row, want_result.scrolled, want_result.bad,
                     {want_result.attr, want_result.bg, want_result.fg, want_result.ch},
                     got_result.col, got_result.row, got_result.scrolled, got_result.bad,
                     {got_result.attr, got_result.bg, got_result.fg, got_result.ch});
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (!idle_on) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 7);
    end
  end

  task automatic send_word(logic [1:0] mode, logic [7:0] ch, logic [7:0] px, logic [6:0] py);
    if (idle_on && burst_left <= 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= 24'($urandom);
      s_tuser  <= 2'($urandom);
      repeat ($urandom_range(0, 7)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, py, px, ch};
    s_tuser  <= mode;
    do @(posedge clk); while (s_tready !== 1'b1);
    due_results.push_back(predict_console_step(mode, ch, px, py));
    burst_left--;
  endtask

  // sender pauses until every result word is back
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_COLUMNS: reg_cols = val;
      REG_ROWS:    reg_rows = val[6:0];
      REG_FG:      reg_fg   = val;
      REG_BG:      reg_bg   = val;
      REG_ATTR:    reg_attr = val;
      default: ;
    endcase
  endtask

  task automatic set_geometry(logic [7:0] cols, logic [6:0] rows);
    drain();
    write_reg(REG_COLUMNS, cols);
    write_reg(REG_ROWS, {1'b0, rows});
  endtask

  task automatic test_reset_screen();
    send_word(MODE_READ, 8'h00, 8'd0, 7'd0);
    send_word(MODE_READ, 8'h00, 8'd79, 7'd23);
    send_word(MODE_READ, 8'h00, 8'd80, 7'd0);
    send_word(MODE_READ, 8'h00, 8'd255, 7'd127);
  endtask

  task automatic test_put_bytes();
    drain();
    write_reg(REG_FG, 8'h1f);
    write_reg(REG_BG, 8'h80);
    write_reg(REG_ATTR, 8'ha5);
    send_word(MODE_PUT, 8'h41, 8'd0, 7'd0);
    send_word(MODE_PUT, 8'hff, 8'd0, 7'd0);
    send_word(MODE_PUT, 8'h00, 8'd0, 7'd0);
    send_word(MODE_PUT, CH_BACKSPACE, 8'd0, 7'd0);
    send_word(MODE_PUT, CH_RETURN, 8'd0, 7'd0);
    send_word(MODE_PUT, CH_BACKSPACE, 8'd0, 7'd0);
    send_word(MODE_PUT, CH_NEWLINE, 8'd0, 7'd0);
    // wrap pending at the last column, then wrap with scroll
    send_word(MODE_SET, 8'h00, 8'd78, 7'd23);
    send_word(MODE_PUT, 8'h78, 8'd0, 7'd0);
    send_word(MODE_PUT, 8'h79, 8'd0, 7'd0);
    send_word(MODE_PUT, 8'h7a, 8'd0, 7'd0);
    send_word(MODE_PUT, CH_NEWLINE, 8'd0, 7'd0);
    send_word(MODE_READ, 8'h00, 8'd78, 7'd21);
  endtask

  task automatic test_set_cursor();
    send_word(MODE_SET, 8'h00, 8'd80, 7'd6);
    send_word(MODE_SET, 8'h00, 8'd11, 7'd24);
    send_word(MODE_SET, 8'h00, 8'd255, 7'd127);
    send_word(MODE_READ, 8'h00, 8'd0, 7'd24);
  endtask

  task automatic test_clear_screen();
    send_word(MODE_CLEAR, 8'h00, 8'd0, 7'd0);
    send_word(MODE_READ, 8'h00, 8'd0, 7'd0);
  endtask

  task automatic test_geometry_extremes();
    set_geometry(8'd0, 7'd0);
    send_word(MODE_PUT, 8'h51, 8'd0, 7'd0);
    send_word(MODE_PUT, 8'h52, 8'd0, 7'd0);
    send_word(MODE_SET, 8'h00, 8'd1, 7'd1);
    set_geometry(8'd255, 7'd127);
    send_word(MODE_SET, 8'h00, 8'd127, 7'd63);
    send_word(MODE_PUT, 8'h4d, 8'd0, 7'd0);
    send_word(MODE_PUT, 8'h4e, 8'd0, 7'd0);
    send_word(MODE_READ, 8'h00, 8'd127, 7'd62);
    set_geometry(8'd128, 7'd64);
    send_word(MODE_READ, 8'h00, 8'd0, 7'd63);
    send_word(MODE_CLEAR, 8'h00, 8'd0, 7'd0);
  endtask

  // cursor left outside the area by a shrink; cells outside keep contents
  task automatic test_shrink();
    set_geometry(8'd80, 7'd24);
    send_word(MODE_SET, 8'h00, 8'd70, 7'd20);
    set_geometry(8'd10, 7'd5);
    send_word(MODE_PUT, CH_BACKSPACE, 8'd0, 7'd0);
    send_word(MODE_PUT, 8'h53, 8'd0, 7'd0);
    set_geometry(8'd80, 7'd24);
    send_word(MODE_READ, 8'h00, 8'd0, 7'd3);
    send_word(MODE_READ, 8'h00, 8'd20, 7'd4);
  endtask

  task automatic send_random_word();
    int         pick;
    logic [1:0] mode;
    logic [7:0] ch;
    logic [7:0] px;
    logic [6:0] py;
    pick = $urandom_range(0, 99);
    ch   = 8'($urandom);
    px   = 8'($urandom);
    py   = 7'($urandom);
    if (pick < 55) begin
      mode = MODE_PUT;
      case ($urandom_range(0, 9))
        0, 1: ch = CH_NEWLINE;
        2: ch = CH_RETURN;
        3: ch = CH_BACKSPACE;
        default: ;
      endcase
    end else if (pick < 97) begin
      mode = (pick < 68) ? MODE_SET : MODE_READ;
      if ($urandom_range(0, 3) != 0) begin
        px = 8'($urandom_range(0, cols_used() - 1));
        py = 7'($urandom_range(0, rows_used() - 1));
      end
    end else begin
      mode = MODE_CLEAR;
    end
    send_word(mode, ch, px, py);
  endtask

  task automatic test_random_traffic();
    logic [7:0] cols;
    logic [6:0] rows;
    for (int p = 0; p < 12; p++) begin
      case (p)
        0:  begin cols = 8'd80;  rows = 7'd24;  end
        9:  begin cols = 8'd255; rows = 7'd3;   end
        10: begin cols = 8'd2;   rows = 7'd127; end
        11: begin cols = 8'd0;   rows = 7'd0;   end
        default: begin
          cols = 8'($urandom_range(1, 40));
          rows = 7'($urandom_range(1, 12));
        end
      endcase
      set_geometry(cols, rows);
      write_reg(REG_FG, (p == 1) ? 8'h00 : (p == 2) ? 8'hff : 8'($urandom));
      write_reg(REG_BG, (p == 1) ? 8'h00 : (p == 2) ? 8'hff : 8'($urandom));
      write_reg(REG_ATTR, (p == 1) ? 8'h00 : (p == 2) ? 8'hff : 8'($urandom));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
        if (i == 60) drain();
        send_random_word();
      end
    end
  endtask

  initial begin
    for (int i = 0; i < CELL_DEPTH; i++) screen_model[i] = RESET_CELL;
    cur_x     = 0;
    cur_y     = 0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_screen();
    test_put_bytes();
    test_set_cursor();
    test_clear_screen();
    test_geometry_extremes();
    test_shrink();
    test_random_traffic();

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/tccw_pkg.sv
hw/rtl/tccw_ram.sv
hw/rtl/tccw_front.sv
hw/rtl/tccw_back.sv
hw/rtl/text_console_cell_writer_core.sv
tb/tb_text_console_cell_writer_core.sv
